FILE: src/ttf_pkg.sv
// ----------------------------------------------------------------------------
// ttf_pkg: shared types and constants for the triangle tangent frame unit
// Holds the triangle record passed from front to back and the back-end state type.
// ----------------------------------------------------------------------------
`default_nettype none
package ttf_pkg;
	localparam int unsigned COORD_WIDTH = 32;  // vertex coordinate width
	localparam int unsigned DW = COORD_WIDTH + 2;  // delta width (coord + 2; a delta needs at most coord + 1)
	localparam int unsigned PW = 2 * DW;  // exact difference of products, signed

	typedef struct packed {
		logic signed [DW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
		logic signed [DW-1:0] du1, dv1, du2, dv2;
	} tri_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_SUM, ST_NORM_LEN, ST_NORM_SHIFT, ST_NORM_SQ,
		ST_SQRT, ST_DIV, ST_NEXT, ST_OUT
	} bst_t;
endpackage
`default_nettype wire

FILE: src/triangle_tangent_frame_unit.sv
// Path from the third vertex to the result word: a zero determinant or tangent skips
// normalization, a zero bitangent ends it after the tangent, otherwise both vectors
// are normalized (32-step square root, OUT_FRAC+32-step divide).
// The back end takes one triangle at a time; the front holds one finished
// triangle and then stops taking vertices until the back end picks it up.
// Reset: arst_n clears vertex slot, queue and back-end state; held data is not cleared.
// ----------------------------------------------------------------------------
// triangle_tangent_frame_unit: per-triangle unit tangent and bitangent
// Front gathers vertices, back computes and normalizes.
// ----------------------------------------------------------------------------
`default_nettype none
module triangle_tangent_frame_unit #(
	parameter int OUT_FRAC = 14
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [159:0] s_tdata,  // pos_x, pos_y, pos_z, tex_u, tex_v
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [103:0]      m_tdata   // tan_x..z, bitan_x..z, degenerate, pad
);
	logic qv, qr;
	ttf_pkg::tri_t qd;
	logic [96:0] od;

	ttf_front u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready),
		.px(s_tdata[31:0]), .py(s_tdata[63:32]), .pz(s_tdata[95:64]),
		.tu(s_tdata[127:96]), .tv(s_tdata[159:128]),
		.q_valid(qv), .q_ready(qr), .q_data(qd)
	);
	ttf_back #(.OUT_FRAC(OUT_FRAC)) u_back (
		.clk, .arst_n, .q_valid(qv), .q_ready(qr), .q_data(qd),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(od)
	);
	assign m_tdata = {7'd0, od};
endmodule
`default_nettype wire

FILE: src/ttf_front.sv
// ----------------------------------------------------------------------------
// ttf_front: vertex gathering
// Holds the first two vertices of a triangle and emits edge and UV deltas.
// ----------------------------------------------------------------------------
`default_nettype none
module ttf_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [ttf_pkg::COORD_WIDTH-1:0] px, py, pz, tu, tv,
	output logic                                 q_valid,
	input  wire logic                            q_ready,
	output ttf_pkg::tri_t                        q_data
);
	logic [1:0] slot_q;
	logic signed [ttf_pkg::COORD_WIDTH-1:0] hx_q [2], hy_q [2], hz_q [2], hu_q [2], hv_q [2];
	logic full_q;
	ttf_pkg::tri_t tri_q;
	logic acc;

	function automatic logic signed [ttf_pkg::DW-1:0] dlt(
		input logic signed [ttf_pkg::COORD_WIDTH-1:0] a,
		input logic signed [ttf_pkg::COORD_WIDTH-1:0] b);
		logic signed [ttf_pkg::DW-1:0] ea, eb;
		begin
			ea = ttf_pkg::DW'(a);
			eb = ttf_pkg::DW'(b);
			dlt = ea - eb;
		end
	endfunction

	assign in_ready = !full_q || q_ready;
	assign acc = in_valid && in_ready;
	assign q_valid = full_q;
	assign q_data = tri_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			full_q <= 1'b0;
		end else begin
			if (acc) begin
				if (slot_q < 2'd2) slot_q <= slot_q + 2'd1;
				else slot_q <= '0;
			end
			if (acc && slot_q >= 2'd2) full_q <= 1'b1;
			else if (q_ready) full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			if (slot_q < 2'd2) begin
				hx_q[slot_q[0]] <= px; hy_q[slot_q[0]] <= py; hz_q[slot_q[0]] <= pz;
				hu_q[slot_q[0]] <= tu; hv_q[slot_q[0]] <= tv;
			end else begin
				tri_q.e1x <= dlt(hx_q[1], hx_q[0]);
				tri_q.e1y <= dlt(hy_q[1], hy_q[0]);
				tri_q.e1z <= dlt(hz_q[1], hz_q[0]);
				tri_q.e2x <= dlt(px, hx_q[0]);
				tri_q.e2y <= dlt(py, hy_q[0]);
				tri_q.e2z <= dlt(pz, hz_q[0]);
				tri_q.du1 <= dlt(hu_q[1], hu_q[0]);
				tri_q.dv1 <= dlt(hv_q[1], hv_q[0]);
				tri_q.du2 <= dlt(tu, hu_q[0]);
				tri_q.dv2 <= dlt(tv, hv_q[0]);
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/ttf_back.sv
// ----------------------------------------------------------------------------
// ttf_back: frame computation
// One shared multiplier computes determinant and vectors; a bit-serial
// square root and divider normalize each vector in turn.
// ----------------------------------------------------------------------------
`default_nettype none
module ttf_back #(
	parameter int OUT_FRAC = 14
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	output logic               q_ready,
	input  wire ttf_pkg::tri_t q_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [96:0]        out_data
);
	localparam int PW = ttf_pkg::PW;
	localparam int QW = OUT_FRAC + 32;

	ttf_pkg::bst_t st_q, st_d;
	ttf_pkg::tri_t t_q;
	logic [4:0] idx_q;
	logic signed [PW-1:0] p_q [14];
	logic signed [PW-1:0] v_q [7];
	logic [2:0] vi_q;
	logic [1:0] ci_q;
	logic [6:0] len_q;
	logic [30:0] m_q [3];
	logic [63:0] s_q, rem_q;
	logic [33:0] r_q;
	logic [5:0] it_q;
	logic [QW-1:0] num_q, qt_q;
	logic [QW:0] dr_q;
	logic [15:0] o_q [6];
	logic dg_q;
	logic signed [ttf_pkg::DW-1:0] ma, mb;
	logic signed [PW-1:0] prod;
	logic [PW-1:0] mag [3];
	logic [6:0] bl [3];
	logic [6:0] mx;
	logic [31:0] rr;
	logic [QW:0] dsh, dnx;
	logic dge;
	logic [QW-1:0] qnx;

	function automatic logic [15:0] sat(input logic [QW-1:0] q, input logic ng);
		begin
			if (q > QW'(ng ? 32768 : 32767)) sat = ng ? 16'h8000 : 16'h7fff;
			else sat = ng ? 16'(-q) : q[15:0];
		end
	endfunction

	// product schedule: det pair, then a t pair per axis, then a b pair per axis
	always_comb begin
		ma = '0; mb = '0;
		case (idx_q)
			5'd0: begin ma = t_q.du1; mb = t_q.dv2; end
			5'd1: begin ma = t_q.du2; mb = t_q.dv1; end
			5'd2: begin ma = t_q.dv2; mb = t_q.e1x; end
			5'd3: begin ma = t_q.dv1; mb = t_q.e2x; end
			5'd4: begin ma = t_q.dv2; mb = t_q.e1y; end
			5'd5: begin ma = t_q.dv1; mb = t_q.e2y; end
			5'd6: begin ma = t_q.dv2; mb = t_q.e1z; end
			5'd7: begin ma = t_q.dv1; mb = t_q.e2z; end
			5'd8: begin ma = t_q.du1; mb = t_q.e2x; end
			5'd9: begin ma = t_q.du2; mb = t_q.e1x; end
			5'd10: begin ma = t_q.du1; mb = t_q.e2y; end
			5'd11: begin ma = t_q.du2; mb = t_q.e1y; end
			5'd12: begin ma = t_q.du1; mb = t_q.e2z; end
			5'd13: begin ma = t_q.du2; mb = t_q.e1z; end
			default: begin ma = '0; mb = '0; end
		endcase
		prod = PW'(ma) * PW'(mb);
	end

	always_comb begin
		mx = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = v_q[{vi_q[1:0] == 2'd0 ? 3'd1 : 3'd4} + 3'(i)][PW-1] ?
				PW'(-v_q[(vi_q[1:0] == 2'd0 ? 3'd1 : 3'd4) + 3'(i)]) :
				PW'(v_q[(vi_q[1:0] == 2'd0 ? 3'd1 : 3'd4) + 3'(i)]);
			bl[i] = '0;
			for (int b = 0; b < PW; b++) if (mag[i][b]) bl[i] = 7'(b + 1);
			if (bl[i] > mx) mx = bl[i];
		end
		rr = 32'(r_q >> 1);
		// one restoring division step
		dsh = {dr_q[QW-1:0], num_q[QW-1]};
		dge = (dsh >= (QW+1)'(r_q));
		dnx = dge ? dsh - (QW+1)'(r_q) : dsh;
		qnx = {qt_q[QW-2:0], dge};
	end

	assign q_ready = (st_q == ttf_pkg::ST_IDLE);
	assign out_valid = (st_q == ttf_pkg::ST_OUT);
	assign out_data = {dg_q, o_q[5], o_q[4], o_q[3], o_q[2], o_q[1], o_q[0]};

	always_comb begin
		st_d = st_q;
		case (st_q)
			ttf_pkg::ST_IDLE: if (q_valid) st_d = ttf_pkg::ST_MUL;
			ttf_pkg::ST_MUL: if (idx_q == 5'd13) st_d = ttf_pkg::ST_SUM;
			ttf_pkg::ST_SUM: st_d = ttf_pkg::ST_NORM_LEN;
			ttf_pkg::ST_NORM_LEN:
				st_d = (dg_q || mx == 7'd0) ? ttf_pkg::ST_OUT : ttf_pkg::ST_NORM_SHIFT;
			ttf_pkg::ST_NORM_SHIFT: st_d = ttf_pkg::ST_NORM_SQ;
			ttf_pkg::ST_NORM_SQ: if (ci_q == 2'd2) st_d = ttf_pkg::ST_SQRT;
			ttf_pkg::ST_SQRT: if (it_q == 6'd31) st_d = ttf_pkg::ST_DIV;
			ttf_pkg::ST_DIV: if (it_q == 6'(QW - 1) && ci_q == 2'd2) st_d = ttf_pkg::ST_NEXT;
			ttf_pkg::ST_NEXT: st_d = vi_q[0] ? ttf_pkg::ST_OUT : ttf_pkg::ST_NORM_LEN;
			ttf_pkg::ST_OUT: if (out_ready) st_d = ttf_pkg::ST_IDLE;
			default: st_d = ttf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ttf_pkg::ST_IDLE;
		else st_q <= st_d;
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ttf_pkg::ST_IDLE: begin
				t_q <= q_data; idx_q <= '0; vi_q <= '0;
			end
			ttf_pkg::ST_MUL: begin
				p_q[idx_q[3:0]] <= prod; idx_q <= idx_q + 5'd1;
			end
			ttf_pkg::ST_SUM: begin
				v_q[0] <= p_q[0] - p_q[1];
				// negative det flips both vectors
				for (int i = 0; i < 6; i++)
					v_q[i+1] <= (p_q[0] < p_q[1]) ? p_q[3+2*i] - p_q[2+2*i] :
						p_q[2+2*i] - p_q[3+2*i];
				dg_q <= (p_q[0] == p_q[1]);
				for (int i = 0; i < 6; i++) o_q[i] <= '0;
			end
			ttf_pkg::ST_NORM_LEN: begin
				if (mx == 7'd0) begin
					dg_q <= 1'b1;
					for (int i = 0; i < 6; i++) o_q[i] <= '0;
				end
				len_q <= mx; ci_q <= '0; s_q <= '0;
			end
			ttf_pkg::ST_NORM_SHIFT: begin
				for (int i = 0; i < 3; i++)
					m_q[i] <= (len_q > 7'd31) ? 31'(mag[i] >> (len_q - 7'd31)) :
						31'(mag[i] << (7'd31 - len_q));
			end
			ttf_pkg::ST_NORM_SQ: begin
				s_q <= s_q + 64'(m_q[ci_q]) * 64'(m_q[ci_q]);
				ci_q <= ci_q + 2'd1;
				it_q <= '0; rem_q <= '0; r_q <= '0;
			end
			ttf_pkg::ST_SQRT: begin
				// restoring square root, two radicand bits per step
				if ({rem_q[61:0], s_q[63:62]} >= {r_q[31:0], 2'b01}) begin
					rem_q <= {rem_q[61:0], s_q[63:62]} - 64'({r_q[31:0], 2'b01});
					r_q <= {r_q[32:0], 1'b1};
				end else begin
					rem_q <= {rem_q[61:0], s_q[63:62]};
					r_q <= {r_q[32:0], 1'b0};
				end
				s_q <= {s_q[61:0], 2'b00};
				it_q <= (it_q == 6'd31) ? '0 : it_q + 6'd1;
				ci_q <= '0;
				if (it_q == 6'd31) begin
					num_q <= (QW'(m_q[0]) << OUT_FRAC) + QW'(32'({r_q[32:0], 1'b0} >> 1));
					dr_q <= '0; qt_q <= '0;
				end
			end
			ttf_pkg::ST_DIV: begin
				// restoring division, one quotient bit per step
				if (it_q == 6'(QW - 1)) begin
					it_q <= '0;
					o_q[(vi_q[0] ? 3'd3 : 3'd0) + 3'(ci_q)] <= sat(qnx,
						v_q[(vi_q[0] ? 3'd4 : 3'd1) + 3'(ci_q)][PW-1]);
					ci_q <= ci_q + 2'd1;
					num_q <= (QW'(m_q[ci_q == 2'd2 ? 2'd0 : ci_q + 2'd1]) << OUT_FRAC)
						+ QW'(rr);
					dr_q <= '0; qt_q <= '0;
				end else begin
					it_q <= it_q + 6'd1;
					num_q <= {num_q[QW-2:0], 1'b0};
					dr_q <= dnx;
					qt_q <= qnx;
				end
			end
			ttf_pkg::ST_NEXT: vi_q <= vi_q + 3'd1;
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_noq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !q_ready) else $error("accept while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_dg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dg_q |-> o_q[0] == 16'd0) else $error("degenerate nonzero");
`endif
endmodule
`default_nettype wire

FILE: tb/triangle_tangent_frame_unit_tb.sv
// ----------------------------------------------------------------------------
// triangle_tangent_frame_unit_tb: self-checking bench for the tangent frame unit
// Streams vertices, predicts the unit tangent and bitangent of every third
// vertex in fixed point, and checks each result word field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module triangle_tangent_frame_unit_tb;
	localparam int OUT_FRAC = 14;

	typedef struct {
		logic signed [31:0] px, py, pz, u, v;
	} vertex_t;

	typedef struct {
		logic signed [15:0] tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z;
		logic               degenerate;
	} frame_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	wire          s_tready;
	logic [159:0] s_tdata;   // pos_x, pos_y, pos_z, tex_u, tex_v
	wire          m_tvalid;
	logic         m_tready;
	wire  [103:0] m_tdata;   // tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z, degenerate, pad

	triangle_tangent_frame_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// predictor state: the two held vertices of the open triangle and the slot
	vertex_t held [2];
	int      slot;
	frame_t  pending_frames[$];
	int      errors;
	int      frames_seen;
	int      degenerate_seen;
	bit      calm;   // last part of the run: no idling on either side

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// find a*b - c*d exactly; operands fit in 34 signed bits
	function automatic logic signed [69:0] cross_diff(logic signed [33:0] a,
			logic signed [33:0] b, logic signed [33:0] c, logic signed [33:0] d);
		logic signed [69:0] p, q;
		p = 70'(a) * 70'(b);
		q = 70'(c) * 70'(d);
		return p - q;
	endfunction

	function automatic int unsigned bit_length(logic [69:0] x);
		int unsigned n;
		n = 0;
		for (int i = 0; i < 70; i++)
			if (x[i])
				n = i + 1;
		return n;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] s);
		logic [63:0] root, b;
		root = 0;
		b = 64'd1 << 62;
		while (b > s)
			b = b >> 2;
		while (b != 0) begin
			if (s >= root + b) begin
				s = s - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	// scale so the largest magnitude sits in [2^30, 2^31), then divide by the
	// floor square root with rounding; magnitudes truncate on the shift
	task automatic to_unit(input logic signed [69:0] c [3], output logic signed [15:0] o [3]);
		logic [69:0]  mag [3];
		logic [63:0]  m [3];
		logic [63:0]  sum, root, q;
		int unsigned  top;
		longint       val;
		top = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = c[i] < 0 ? 70'(-c[i]) : 70'(c[i]);
			if (bit_length(mag[i]) > top)
				top = bit_length(mag[i]);
		end
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			if (top > 31)
				m[i] = 64'(mag[i] >> (top - 31));
			else
				m[i] = 64'(mag[i] << (31 - top));
			sum += m[i] * m[i];
		end
		root = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << OUT_FRAC) + (root >> 1)) / root;
			val = c[i] < 0 ? -longint'(q) : longint'(q);
			if (val > 32767)
				val = 32767;
			if (val < -32768)
				val = -32768;
			o[i] = 16'(val);
		end
	endtask

	// advance the predictor by one accepted vertex
	task automatic predict_vertex(input vertex_t vx);
		logic signed [33:0] e1 [3], e2 [3];
		logic signed [33:0] du1, dv1, du2, dv2;
		logic signed [69:0] det, t [3], b [3];
		logic signed [15:0] ot [3], ob [3];
		frame_t             f;
		if (slot < 2) begin
			held[slot] = vx;
			slot++;
			return;
		end
		slot = 0;
		e1[0] = 34'(held[1].px) - 34'(held[0].px);
		e1[1] = 34'(held[1].py) - 34'(held[0].py);
		e1[2] = 34'(held[1].pz) - 34'(held[0].pz);
		e2[0] = 34'(vx.px) - 34'(held[0].px);
		e2[1] = 34'(vx.py) - 34'(held[0].py);
		e2[2] = 34'(vx.pz) - 34'(held[0].pz);
		du1 = 34'(held[1].u) - 34'(held[0].u);
		dv1 = 34'(held[1].v) - 34'(held[0].v);
		du2 = 34'(vx.u) - 34'(held[0].u);
		dv2 = 34'(vx.v) - 34'(held[0].v);
		det = cross_diff(du1, dv2, du2, dv1);
		for (int i = 0; i < 3; i++) begin
			t[i] = cross_diff(dv2, e1[i], dv1, e2[i]);
			b[i] = cross_diff(du1, e2[i], du2, e1[i]);
			if (det < 0) begin
				t[i] = -t[i];
				b[i] = -b[i];
			end
			ot[i] = 0;
			ob[i] = 0;
		end
		f.degenerate = (det == 0) || (t[0] == 0 && t[1] == 0 && t[2] == 0)
			|| (b[0] == 0 && b[1] == 0 && b[2] == 0);
		if (!f.degenerate) begin
			to_unit(t, ot);
			to_unit(b, ob);
		end
		f.tan_x = ot[0];
		f.tan_y = ot[1];
		f.tan_z = ot[2];
		f.bitan_x = ob[0];
		f.bitan_y = ob[1];
		f.bitan_z = ob[2];
		pending_frames = {pending_frames, f};
	endtask

	// send one vertex word, optionally after a short idle burst; valid stays
	// high after the handshake so back-to-back words need no extra edge
	task automatic send_vertex(input vertex_t vx);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {vx.v, vx.u, vx.pz, vx.py, vx.px};
		do
			@(posedge clk);
		while (!s_tready);
		predict_vertex(vx);
	endtask

	function automatic logic signed [31:0] rand_coord(int mode);
		case (mode)
			0: return 32'($urandom);
			1: return 32'($signed($urandom_range(0, 8191)) - 4096) <<< 16;
			2: return 32'($signed($urandom_range(0, 65535)) - 32768);
			default: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
		endcase
	endfunction

	function automatic vertex_t rand_vertex(int mode);
		vertex_t vx;
		vx.px = rand_coord(mode);
		vx.py = rand_coord(mode);
		vx.pz = rand_coord(mode);
		vx.u = rand_coord(mode);
		vx.v = rand_coord(mode);
		return vx;
	endfunction

	function automatic vertex_t mk(int x, int y, int z, int u, int v);
		vertex_t vx;
		vx.px = x;
		vx.py = y;
		vx.pz = z;
		vx.u = u;
		vx.v = v;
		return vx;
	endfunction

	// directed triangles: a plain unit frame, flipped winding in UV (negative
	// det), zero det, collinear edges, all-equal vertices,
	// and the coordinate extremes that give the widest deltas and products
	task automatic test_directed();
		localparam int ONE = 32'h0001_0000;
		localparam int MX = 32'h7fff_ffff;
		localparam int MN = 32'h8000_0000;
		send_vertex(mk(0, 0, 0, 0, 0));
		send_vertex(mk(ONE, 0, 0, ONE, 0));
		send_vertex(mk(0, ONE, 0, 0, ONE));
		send_vertex(mk(0, 0, 0, 0, 0));
		send_vertex(mk(ONE, 0, 0, 0, ONE));
		send_vertex(mk(0, ONE, 0, ONE, 0));
		send_vertex(mk(0, 0, 0, 0, 0));
		send_vertex(mk(ONE, 0, 0, ONE, ONE));
		send_vertex(mk(0, ONE, 0, 2 * ONE, 2 * ONE));
		send_vertex(mk(0, 0, 0, 0, 0));
		send_vertex(mk(ONE, ONE, ONE, ONE, 0));
		send_vertex(mk(2 * ONE, 2 * ONE, 2 * ONE, 0, ONE));
		send_vertex(mk(5, 5, 5, 5, 5));
		send_vertex(mk(5, 5, 5, 5, 5));
		send_vertex(mk(5, 5, 5, 5, 5));
		send_vertex(mk(MN, MN, MN, MN, MN));
		send_vertex(mk(MX, MN, MX, MX, MN));
		send_vertex(mk(MN, MX, MX, MN, MX));
		send_vertex(mk(MX, MX, MX, MX, MX));
		send_vertex(mk(MN, MX, MN, MN, MX));
		send_vertex(mk(MX, MN, MN, MX, MX));
		send_vertex(mk(-1, 0, 1, -1, 0));
		send_vertex(mk(0, -1, 1, 0, -1));
		send_vertex(mk(1, 1, -1, 1, 1));
	endtask

	// random triangles mixing full-range, mid-scale, small and extreme coords
	task automatic test_random(int count);
		int mode;
		for (int i = 0; i < count; i++) begin
			if (i % 3 == 0)
				mode = $urandom_range(0, 9) < 1 ? 3 : $urandom_range(0, 2);
			if ($urandom_range(0, 29) == 0)
				send_vertex(held[0].px === 'x ? rand_vertex(mode) : held[0]);
			else
				send_vertex(rand_vertex(mode));
		end
	endtask

	// result side: random back-pressure, one check per accepted result word
	always @(posedge clk) begin
		frame_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.tan_x = m_tdata[15:0];
				got.tan_y = m_tdata[31:16];
				got.tan_z = m_tdata[47:32];
				got.bitan_x = m_tdata[63:48];
				got.bitan_y = m_tdata[79:64];
				got.bitan_z = m_tdata[95:80];
				got.degenerate = m_tdata[96];
				frames_seen++;
				if (pending_frames.size() == 0) begin
					$error("result word with nothing expected");
					errors++;
				end else begin
					want = pending_frames.pop_front();
					degenerate_seen += want.degenerate;
					if (got.tan_x !== want.tan_x) begin
						$error("tan_x: expected %0d, got %0d", want.tan_x, got.tan_x);
						errors++;
					end
					if (got.tan_y !== want.tan_y) begin
						$error("tan_y: expected %0d, got %0d", want.tan_y, got.tan_y);
						errors++;
					end
					if (got.tan_z !== want.tan_z) begin
						$error("tan_z: expected %0d, got %0d", want.tan_z, got.tan_z);
						errors++;
					end
					if (got.bitan_x !== want.bitan_x) begin
						$error("bitan_x: expected %0d, got %0d", want.bitan_x, got.bitan_x);
						errors++;
					end
					if (got.bitan_y !== want.bitan_y) begin
						$error("bitan_y: expected %0d, got %0d", want.bitan_y, got.bitan_y);
						errors++;
					end
					if (got.bitan_z !== want.bitan_z) begin
						$error("bitan_z: expected %0d, got %0d", want.bitan_z, got.bitan_z);
						errors++;
					end
					if (got.degenerate !== want.degenerate) begin
						$error("degenerate: expected %0d, got %0d", want.degenerate,
							got.degenerate);
						errors++;
					end
				end
			end
			if (calm || $urandom_range(0, 3) != 0)
				m_tready <= 1'b1;
			else
				m_tready <= 1'b0;
		end
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		errors = 0;
		frames_seen = 0;
		degenerate_seen = 0;
		slot = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1200);
		calm = 1'b1;
		test_random(300);
		s_tvalid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (300)
			@(posedge clk);
		$display("covered %0d triangles, %0d of them degenerate", frames_seen,
			degenerate_seen);
		if (errors == 0 && pending_frames.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
